### sv/u2u_pkg.sv
`default_nettype none

package u2u_pkg;

    localparam logic [15:0] C_UNIT_BAD  = 16'hFFFD;
    localparam logic [20:0] C_POINT_TOP = 21'h10FFFF;
    localparam logic [20:0] C_PLANE1    = 21'h010000;
    localparam logic [15:0] C_HIGH_SUR  = 16'hD800;
    localparam logic [15:0] C_LOW_SUR   = 16'hDC00;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_COLLECT = 3'b010,
        MODE_SWALLOW = 3'b100
    } t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [1:0]  due;
        logic [20:0] point;
    } t_state;

    typedef struct packed {
        t_state           nxt;
        logic [1:0][15:0] units;
        logic [1:0]       cnt;
    } t_dec;

    typedef struct packed {
        logic        emit;
        logic [15:0] unit;
        t_mode       mode;
        logic [1:0]  due;
        logic [20:0] point;
    } t_fresh;

endpackage

`default_nettype wire

### sv/u2u_byte_if.sv
`default_nettype none

interface u2u_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

### sv/u2u_unit_if.sv
`default_nettype none

interface u2u_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_of_run;

    modport source (output valid, output code_unit, output last_of_run, input ready);
    modport sink (input valid, input code_unit, input last_of_run, output ready);
endinterface

`default_nettype wire

### sv/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 stream transcoder.
// The byte channel i_byte carries one UTF-8 byte per word together with an
// end_of_stream flag that marks the final byte of a string. The unit channel
// o_unit carries UTF-16 code units; last_of_run is set on the last unit that
// a given byte produced. A byte may produce no unit, one unit or two units.
// Each accepted byte is decoded in the cycle it is accepted, and its units
// appear on o_unit in the next cycle. The result buffer holds two units. A
// byte is taken in every cycle as long as each byte yields at most one unit
// and the receiver keeps up; a byte that yields two units holds the byte
// channel off until its first unit has been taken.
// When the receiver stalls, the buffered units wait and the byte channel is
// held off once the buffer cannot drain in the current cycle.
// Reset returns the decoder to its idle mode and empties the result buffer.
// A byte with end_of_stream set also returns the decoder to idle afterwards.
`default_nettype none

module utf8_to_utf16_transcoder (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u2u_byte_if.sink    i_byte,
    u2u_unit_if.source  o_unit
);

    u2u_pkg::t_state  r_state;
    u2u_pkg::t_state  n_state;
    u2u_pkg::t_dec    dec;
    logic [1:0][15:0] r_units;
    logic [1:0][15:0] n_units;
    logic [1:0]       r_left;
    logic [1:0]       n_left;
    logic             r_rd;
    logic             n_rd;
    logic             in_acc;
    logic             out_acc;

    u2u_decoder u_dec (
        .i_byte  (i_byte.in_byte),
        .i_eos   (i_byte.end_of_stream),
        .i_state (r_state),
        .o_dec   (dec)
    );

    assign out_acc            = o_unit.valid & o_unit.ready;
    assign i_byte.ready       = (r_left == 2'd0) || ((r_left == 2'd1) && o_unit.ready);
    assign in_acc             = i_byte.valid & i_byte.ready;
    assign o_unit.valid       = (r_left != 2'd0);
    assign o_unit.code_unit   = r_units[r_rd];
    assign o_unit.last_of_run = (r_left == 2'd1);

    always_comb begin
        n_state = r_state;
        n_units = r_units;
        n_left  = r_left;
        n_rd    = r_rd;
        if (out_acc) begin
            n_left = r_left - 2'd1;
            n_rd   = ~r_rd;
        end
        if (in_acc) begin
            n_state = dec.nxt;
            if (dec.cnt != 2'd0) begin
                n_units = dec.units;
                n_left  = dec.cnt;
                n_rd    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode  <= u2u_pkg::MODE_IDLE;
            r_state.due   <= 2'd0;
            r_state.point <= 21'd0;
            r_left        <= 2'd0;
            r_rd          <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_rd    <= n_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_units <= n_units;
    end

endmodule

`default_nettype wire

### sv/u2u_decoder.sv
`default_nettype none

module u2u_decoder (
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eos,
    input  wire u2u_pkg::t_state i_state,
    output u2u_pkg::t_dec        o_dec
);

    function automatic u2u_pkg::t_fresh fresh(input logic [7:0] b);
        u2u_pkg::t_fresh f;
        f.emit  = 1'b0;
        f.unit  = u2u_pkg::C_UNIT_BAD;
        f.mode  = u2u_pkg::MODE_IDLE;
        f.due   = 2'd0;
        f.point = 21'd0;
        if (b[7] == 1'b0) begin
            f.emit = 1'b1;
            f.unit = {8'd0, b};
        end else if (b[7:6] == 2'b10) begin
            f.emit = 1'b1;
            f.mode = u2u_pkg::MODE_SWALLOW;
        end else if (b[7:5] == 3'b110) begin
            f.mode  = u2u_pkg::MODE_COLLECT;
            f.due   = 2'd1;
            f.point = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            f.mode  = u2u_pkg::MODE_COLLECT;
            f.due   = 2'd2;
            f.point = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            f.mode  = u2u_pkg::MODE_COLLECT;
            f.due   = 2'd3;
            f.point = {18'd0, b[2:0]};
        end else begin
            f.emit = 1'b1;
            f.mode = u2u_pkg::MODE_SWALLOW;
        end
        return f;
    endfunction

    logic            cont;
    logic [20:0]     acc;
    logic [1:0]      due_dec;
    logic [19:0]     offs;
    u2u_pkg::t_fresh fr;

    assign cont    = (i_byte[7:6] == 2'b10);
    assign acc     = {i_state.point[14:0], i_byte[5:0]};
    assign due_dec = i_state.due - 2'd1;
    assign offs    = 20'(acc - u2u_pkg::C_PLANE1);
    assign fr      = fresh(i_byte);

    always_comb begin
        o_dec.nxt   = i_state;
        o_dec.units = '0;
        o_dec.cnt   = 2'd0;

        unique case (i_state.mode)
            u2u_pkg::MODE_COLLECT: begin
                if (cont) begin
                    o_dec.nxt.point = acc;
                    o_dec.nxt.due   = due_dec;
                    if (due_dec == 2'd0) begin
                        o_dec.nxt.mode = u2u_pkg::MODE_IDLE;
                        if (acc > u2u_pkg::C_POINT_TOP) begin
                            o_dec.units[0] = u2u_pkg::C_UNIT_BAD;
                            o_dec.cnt      = 2'd1;
                            o_dec.nxt.mode = u2u_pkg::MODE_SWALLOW;
                        end else if (acc < u2u_pkg::C_PLANE1) begin
                            o_dec.units[0] = acc[15:0];
                            o_dec.cnt      = 2'd1;
                        end else begin
                            o_dec.units[0] = u2u_pkg::C_HIGH_SUR | {6'd0, offs[19:10]};
                            o_dec.units[1] = u2u_pkg::C_LOW_SUR | {6'd0, offs[9:0]};
                            o_dec.cnt      = 2'd2;
                        end
                    end
                end else begin
                    o_dec.units[0]  = u2u_pkg::C_UNIT_BAD;
                    o_dec.units[1]  = fr.unit;
                    o_dec.cnt       = fr.emit ? 2'd2 : 2'd1;
                    o_dec.nxt.mode  = fr.mode;
                    o_dec.nxt.due   = fr.due;
                    o_dec.nxt.point = fr.point;
                end
            end
            u2u_pkg::MODE_SWALLOW: begin
                if (!cont) begin
                    o_dec.units[0]  = fr.unit;
                    o_dec.cnt       = fr.emit ? 2'd1 : 2'd0;
                    o_dec.nxt.mode  = fr.mode;
                    o_dec.nxt.due   = fr.due;
                    o_dec.nxt.point = fr.point;
                end
            end
            default: begin
                o_dec.units[0]  = fr.unit;
                o_dec.cnt       = fr.emit ? 2'd1 : 2'd0;
                o_dec.nxt.mode  = fr.mode;
                o_dec.nxt.due   = fr.due;
                o_dec.nxt.point = fr.point;
            end
        endcase

        if (i_eos) begin
            if (o_dec.nxt.mode == u2u_pkg::MODE_COLLECT) begin
                o_dec.units[o_dec.cnt[0]] = u2u_pkg::C_UNIT_BAD;
                o_dec.cnt                 = o_dec.cnt + 2'd1;
            end
            o_dec.nxt.mode  = u2u_pkg::MODE_IDLE;
            o_dec.nxt.due   = 2'd0;
            o_dec.nxt.point = 21'd0;
        end
    end

endmodule

`default_nettype wire
